// ===== rtl/core/tsc_pkg.sv =====
// Shared types and constants for the sensor compensation block.
package tsc_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_TEMP    = 3'd0,
        CFG_CAL_PRESS_A = 3'd1,
        CFG_CAL_PRESS_B = 3'd2,
        CFG_CAL_PRESS_C = 3'd3,
        CFG_CAL_HUM_A   = 3'd4,
        CFG_CAL_HUM_B   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [19:0] adc_press;
        logic [19:0] adc_temp;
        logic [15:0] adc_hum;
    } t_item;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] press_a;
        logic [63:0] press_b;
        logic [15:0] press_c;
        logic [63:0] hum_a;
        logic [7:0]  hum_b;
    } t_cal;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_MTA, S_MW, S_MTB, S_TF,
        S_MSQ, S_MV2A, S_MV2B, S_MX1, S_MX2, S_MDEN, S_MNUM,
        S_DIVI, S_DIV, S_DIVF, S_MW1A, S_MW1B, S_MW2, S_PFIN, S_PDIV,
        S_HL, S_HI1, S_HI2, S_HIN, S_HR, S_HX, S_HS, S_HH1, S_HC, S_DONE
    } t_state;

    localparam logic [63:0] K_T_OFS   = 64'd128000;
    localparam logic [63:0] K_P_FULL  = 64'd1048576;
    localparam logic [63:0] K_P_SCALE = 64'd3125;
    localparam logic [63:0] K_P_BIAS  = 64'h0000_8000_0000_0000;
    localparam logic [31:0] K_H_OFS   = 32'd76800;
    localparam logic [31:0] K_H_RND   = 32'd16384;
    localparam logic [31:0] K_H_ADD   = 32'd32768;
    localparam logic [31:0] K_H_BASE  = 32'd2097152;
    localparam logic [31:0] K_H_RND2  = 32'd8192;
    localparam logic [31:0] K_H_MAX   = 32'd419430400;
    localparam logic [6:0]  K_H_PCT   = 7'd100;

endpackage

// ===== rtl/core/tsc_front.sv =====
// Front end: configuration registers and acceptance of input items.
module tsc_front import tsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_item       i_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_q_full,
    output t_push       o_push,
    output t_cal        o_cal
);

    t_cal r_cal;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = i_q_full;
    assign o_push.valid = i_valid && !i_q_full;
    assign o_push.item  = i_item;
    assign o_cal        = r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CAL_TEMP:    r_cal.temp    <= i_cfg_data[47:0];
                CFG_CAL_PRESS_A: r_cal.press_a <= i_cfg_data;
                CFG_CAL_PRESS_B: r_cal.press_b <= i_cfg_data;
                CFG_CAL_PRESS_C: r_cal.press_c <= i_cfg_data[15:0];
                CFG_CAL_HUM_A:   r_cal.hum_a   <= i_cfg_data;
                CFG_CAL_HUM_B:   r_cal.hum_b   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/tsc_queue.sv =====
// Two-entry item queue between the front end and the compensation engine.
module tsc_queue import tsc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    logic        pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_push.valid && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== rtl/core/tsc_engine.sv =====
// Back end: sequenced compensation datapath with shared multiplier and divider.
module tsc_engine import tsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cal        i_cal,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_temp,
    output logic [31:0] o_press,
    output logic        o_pvalid,
    output logic [13:0] o_hum
);

    function automatic logic [63:0] sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction

    t_state r_state, n_state;
    logic [1:0]  r_mcnt;
    logic [5:0]  r_dcnt;
    logic [63:0] r_acc;
    t_item       r_it;

    logic [31:0] r_u, r_v, r_ta, r_w, r_tf, r_temp;
    logic [63:0] r_v1, r_sq, r_v2, r_x, r_den, r_num;
    logic        r_neg;
    logic [63:0] r_quo, r_dv;
    logic [64:0] r_rem;
    logic [63:0] r_p, r_q, r_y, r_w1, r_w2, r_pf;
    logic [31:0] r_press;
    logic        r_pval;
    logic [31:0] r_hxx, r_hl, r_i1, r_i2, r_in, r_hr, r_hx, r_s2;
    logic [13:0] r_hum;
    logic        r_ovalid;

    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] h1, h2, h3, h5, h6;
    logic [31:0] h4s;
    logic        is_mul, m_last, out_free;
    logic [63:0] ma, mb, m;
    logic [31:0] mx, my, hs;
    logic [63:0] prod;
    logic [64:0] rem_sh;
    logic        ge;
    logic [63:0] pq, num_mag, den_mag, pf_sum;
    logic [28:0] hcl;
    logic [23:0] hprod;

    assign t1 = {48'b0, i_cal.temp[15:0]};
    assign t2 = sx16(i_cal.temp[31:16]);
    assign t3 = sx16(i_cal.temp[47:32]);
    assign p1 = {48'b0, i_cal.press_a[15:0]};
    assign p2 = sx16(i_cal.press_a[31:16]);
    assign p3 = sx16(i_cal.press_a[47:32]);
    assign p4 = sx16(i_cal.press_a[63:48]);
    assign p5 = sx16(i_cal.press_b[15:0]);
    assign p6 = sx16(i_cal.press_b[31:16]);
    assign p7 = sx16(i_cal.press_b[47:32]);
    assign p8 = sx16(i_cal.press_b[63:48]);
    assign p9 = sx16(i_cal.press_c);
    assign h1 = {56'b0, i_cal.hum_a[7:0]};
    assign h2 = sx16(i_cal.hum_a[23:8]);
    assign h3 = {56'b0, i_cal.hum_a[31:24]};
    assign h4s = {i_cal.hum_a[43:32], 20'b0};
    assign h5 = sx16(i_cal.hum_a[63:48]);
    assign h6 = {{56{i_cal.hum_b[7]}}, i_cal.hum_b};

    assign hs = 32'($signed(r_hx) >>> 15);

    // Operand selection for the shared multiplier.
    always_comb begin
        is_mul = 1'b1;
        ma = '0;
        mb = '0;
        unique case (r_state)
            S_MTA:  begin ma = {32'b0, r_u};   mb = t2;              end
            S_MW:   begin ma = {32'b0, r_v};   mb = {32'b0, r_v};    end
            S_MTB:  begin ma = {32'b0, r_w};   mb = t3;              end
            S_MSQ:  begin ma = r_v1;           mb = r_v1;            end
            S_MV2A: begin ma = r_sq;           mb = p6;              end
            S_MV2B: begin ma = r_v1;           mb = p5;              end
            S_MX1:  begin ma = r_sq;           mb = p3;              end
            S_MX2:  begin ma = r_v1;           mb = p2;              end
            S_MDEN: begin ma = r_x;            mb = p1;              end
            S_MNUM: begin ma = r_num;          mb = K_P_SCALE;       end
            S_MW1A: begin ma = p9;             mb = r_q;             end
            S_MW1B: begin ma = r_y;            mb = r_q;             end
            S_MW2:  begin ma = p8;             mb = r_p;             end
            S_HL:   begin ma = h5;             mb = {32'b0, r_hxx};  end
            S_HI1:  begin ma = {32'b0, r_hxx}; mb = h6;              end
            S_HI2:  begin ma = {32'b0, r_hxx}; mb = h3;              end
            S_HIN:  begin ma = {32'b0, r_i1};  mb = {32'b0, r_i2};   end
            S_HR:   begin ma = {32'b0, r_in};  mb = h2;              end
            S_HX:   begin ma = {32'b0, r_hl};  mb = {32'b0, r_hr};   end
            S_HS:   begin ma = {32'b0, hs};    mb = {32'b0, hs};     end
            S_HH1:  begin ma = {32'b0, r_s2};  mb = h1;              end
            default: is_mul = 1'b0;
        endcase
    end

    // Low 64 bits of a 64 by 64 product over three partial products.
    assign mx     = (r_mcnt == 2'd2) ? ma[63:32] : ma[31:0];
    assign my     = (r_mcnt == 2'd1) ? mb[63:32] : mb[31:0];
    assign prod   = {32'b0, mx} * {32'b0, my};
    assign m      = (r_mcnt == 2'd0) ? prod : r_acc + {prod[31:0], 32'b0};
    assign m_last = (r_mcnt == 2'd2);

    assign rem_sh  = {r_rem[63:0], r_quo[63]};
    assign ge      = (rem_sh >= {1'b0, r_dv});
    assign pq      = r_neg ? (64'd0 - r_quo) : r_quo;
    assign num_mag = r_num[63] ? (64'd0 - r_num) : r_num;
    assign den_mag = r_den[63] ? (64'd0 - r_den) : r_den;
    assign pf_sum  = r_p + r_w1 + r_w2;

    assign hcl   = r_hx[31] ? 29'd0 : ((r_hx > K_H_MAX) ? K_H_MAX[28:0] : r_hx[28:0]);
    assign hprod = {7'b0, hcl[28:12]} * {17'b0, K_H_PCT};

    assign out_free = !r_ovalid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_valid  = r_ovalid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_q_valid) n_state = S_PREP;
            S_PREP: n_state = S_MTA;
            S_MTA:  if (m_last) n_state = S_MW;
            S_MW:   if (m_last) n_state = S_MTB;
            S_MTB:  if (m_last) n_state = S_TF;
            S_TF:   n_state = S_MSQ;
            S_MSQ:  if (m_last) n_state = S_MV2A;
            S_MV2A: if (m_last) n_state = S_MV2B;
            S_MV2B: if (m_last) n_state = S_MX1;
            S_MX1:  if (m_last) n_state = S_MX2;
            S_MX2:  if (m_last) n_state = S_MDEN;
            S_MDEN: if (m_last) n_state = S_MNUM;
            S_MNUM: if (m_last) n_state = S_DIVI;
            S_DIVI: n_state = (r_den == 64'd0) ? S_HL : S_DIV;
            S_DIV:  if (r_dcnt == 6'd63) n_state = S_DIVF;
            S_DIVF: n_state = S_MW1A;
            S_MW1A: if (m_last) n_state = S_MW1B;
            S_MW1B: if (m_last) n_state = S_MW2;
            S_MW2:  if (m_last) n_state = S_PFIN;
            S_PFIN: n_state = S_PDIV;
            S_PDIV: n_state = S_HL;
            S_HL:   if (m_last) n_state = S_HI1;
            S_HI1:  if (m_last) n_state = S_HI2;
            S_HI2:  if (m_last) n_state = S_HIN;
            S_HIN:  if (m_last) n_state = S_HR;
            S_HR:   if (m_last) n_state = S_HX;
            S_HX:   if (m_last) n_state = S_HS;
            S_HS:   if (m_last) n_state = S_HH1;
            S_HH1:  if (m_last) n_state = S_HC;
            S_HC:   n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mcnt   <= 2'd0;
            r_dcnt   <= 6'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (is_mul) r_mcnt <= m_last ? 2'd0 : r_mcnt + 2'd1;
            if (r_state == S_DIV) r_dcnt <= r_dcnt + 6'd1;
            else                  r_dcnt <= 6'd0;
            if (r_state == S_DONE && out_free) r_ovalid <= 1'b1;
            else if (!i_stall)                 r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_mul) r_acc <= m;
        case (r_state)
            S_IDLE: r_it <= i_q_item;
            S_PREP: begin
                r_u <= ({12'b0, r_it.adc_temp} >> 3) - {t1[30:0], 1'b0};
                r_v <= ({12'b0, r_it.adc_temp} >> 4) - t1[31:0];
            end
            S_MTA: if (m_last) r_ta <= 32'($signed(m[31:0]) >>> 11);
            S_MW:  if (m_last) r_w  <= 32'($signed(m[31:0]) >>> 12);
            S_MTB: if (m_last) r_tf <= r_ta + 32'($signed(m[31:0]) >>> 14);
            S_TF: begin
                r_temp <= 32'($signed({r_tf[29:0], 2'b0} + r_tf + 32'd128) >>> 8);
                r_v1   <= {{32{r_tf[31]}}, r_tf} - K_T_OFS;
                r_hxx  <= r_tf - K_H_OFS;
            end
            S_MSQ:  if (m_last) r_sq <= m;
            S_MV2A: if (m_last) r_v2 <= m;
            S_MV2B: if (m_last) r_v2 <= r_v2 + {m[46:0], 17'b0} + {p4[28:0], 35'b0};
            S_MX1:  if (m_last) r_x <= 64'($signed(m) >>> 8);
            S_MX2:  if (m_last) r_x <= r_x + {m[51:0], 12'b0} + K_P_BIAS;
            S_MDEN: if (m_last) begin
                r_den <= 64'($signed(m) >>> 33);
                r_num <= {(K_P_FULL[32:0] - {13'b0, r_it.adc_press}), 31'b0} - r_v2;
            end
            S_MNUM: if (m_last) r_num <= m;
            S_DIVI: begin
                r_neg   <= r_num[63] ^ r_den[63];
                r_quo   <= num_mag;
                r_dv    <= den_mag;
                r_rem   <= '0;
                r_press <= '0;
                r_pval  <= 1'b0;
            end
            S_DIV: begin
                r_rem <= ge ? (rem_sh - {1'b0, r_dv}) : rem_sh;
                r_quo <= {r_quo[62:0], ge};
            end
            S_DIVF: begin
                r_p <= pq;
                r_q <= 64'($signed(pq) >>> 13);
            end
            S_MW1A: if (m_last) r_y  <= m;
            S_MW1B: if (m_last) r_w1 <= 64'($signed(m) >>> 25);
            S_MW2:  if (m_last) r_w2 <= 64'($signed(m) >>> 19);
            S_PFIN: r_pf <= 64'($signed(pf_sum) >>> 8) + {p7[59:0], 4'b0};
            S_PDIV: begin
                // Division by 256 rounds towards zero.
                r_press <= 32'(64'($signed(r_pf + (r_pf[63] ? 64'd255 : 64'd0)) >>> 8));
                r_pval  <= 1'b1;
            end
            S_HL: if (m_last) begin
                r_hl <= 32'($signed({2'b0, r_it.adc_hum, 14'b0} - h4s - m[31:0] + K_H_RND)
                        >>> 15);
            end
            S_HI1: if (m_last) r_i1 <= 32'($signed(m[31:0]) >>> 10);
            S_HI2: if (m_last) r_i2 <= 32'($signed(m[31:0]) >>> 11) + K_H_ADD;
            S_HIN: if (m_last) r_in <= 32'($signed(m[31:0]) >>> 10) + K_H_BASE;
            S_HR:  if (m_last) r_hr <= 32'($signed(m[31:0] + K_H_RND2) >>> 14);
            S_HX:  if (m_last) r_hx <= m[31:0];
            S_HS:  if (m_last) r_s2 <= 32'($signed(m[31:0]) >>> 7);
            S_HH1: if (m_last) r_hx <= r_hx - 32'($signed(m[31:0]) >>> 4);
            S_HC:  r_hum <= hprod[23:10];
            S_DONE: if (out_free) begin
                o_temp   <= r_temp;
                o_press  <= r_press;
                o_pvalid <= r_pval;
                o_hum    <= r_hum;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/thp_sensor_compensation.sv =====
// Top level of the temperature, pressure and humidity compensation block.
// The engine takes the next item only once the last result has gone to its output
// register, and skips the pressure division when the pressure divisor is zero. The engine
// runs 21 multiplications on one shared 32 by 32 multiplier and a one-bit-per-cycle
// divider, while a two-item queue keeps accepting items until it is full.
// Reset is synchronous and active low and clears the queue, engine and calibration.
module thp_sensor_compensation import tsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_adc_press,
    input  logic [19:0] i_adc_temp,
    input  logic [15:0] i_adc_hum,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_temperature_centi_deg,
    output logic [31:0] o_pressure_pa,
    output logic        o_pressure_valid,
    output logic [13:0] o_humidity_centi_pct,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_item in_item;
    t_item q_item;
    t_push push;
    t_cal  cal;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    assign in_item.adc_press = i_adc_press;
    assign in_item.adc_temp  = i_adc_temp;
    assign in_item.adc_hum   = i_adc_hum;

    // The front end holds the calibration and pushes accepted items.
    tsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cal       (cal)
    );

    // The queue decouples item acceptance from the engine.
    tsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // The engine works through one item at a time and holds its result in an
    // output register, so it can start the next item while a result waits.
    tsc_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cal     (cal),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_temp    (o_temperature_centi_deg),
        .o_press   (o_pressure_pa),
        .o_pvalid  (o_pressure_valid),
        .o_hum     (o_humidity_centi_pct)
    );

endmodule
